@@ hdl/amx_pkg.sv @@
// Shared types and constants for the affine matrix inverse block.
package amx_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FLOOR_W = 17;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 17'd1;

  // Register index of the determinant floor.
  localparam logic REG_DET_FLOOR = 1'b0;

  typedef struct packed {
    logic signed [DATA_W-1:0] lin_00;
    logic signed [DATA_W-1:0] lin_01;
    logic signed [DATA_W-1:0] lin_02;
    logic signed [DATA_W-1:0] lin_10;
    logic signed [DATA_W-1:0] lin_11;
    logic signed [DATA_W-1:0] lin_12;
    logic signed [DATA_W-1:0] lin_20;
    logic signed [DATA_W-1:0] lin_21;
    logic signed [DATA_W-1:0] lin_22;
    logic signed [DATA_W-1:0] shift_x;
    logic signed [DATA_W-1:0] shift_y;
    logic signed [DATA_W-1:0] shift_z;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] inv_00;
    logic signed [DATA_W-1:0] inv_01;
    logic signed [DATA_W-1:0] inv_02;
    logic signed [DATA_W-1:0] inv_10;
    logic signed [DATA_W-1:0] inv_11;
    logic signed [DATA_W-1:0] inv_12;
    logic signed [DATA_W-1:0] inv_20;
    logic signed [DATA_W-1:0] inv_21;
    logic signed [DATA_W-1:0] inv_22;
    logic signed [DATA_W-1:0] inv_shift_x;
    logic signed [DATA_W-1:0] inv_shift_y;
    logic signed [DATA_W-1:0] inv_shift_z;
  } out_t;

endpackage

@@ hdl/affine_matrix_inverse.sv @@
// The engine works on one transform at a time, paced by the one-bit-per-cycle
// divider, run for each of nine entries, and by the single shared multiplier.
// A two-entry queue accepts new transactions while the engine works; the
// receiver cannot stall, so each result is strobed for exactly one cycle.
// Reset clears the queue, the sequencer and sets det_floor to 1.
module affine_matrix_inverse #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  amx_pkg::in_t  in_data_i,
  output logic          result_valid_o,
  output amx_pkg::out_t result_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import amx_pkg::*;

  logic [FLOOR_W-1:0] det_floor_q;
  logic               q_valid, q_take;
  in_t                q_item;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DET_FLOOR) ? 32'(det_floor_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_floor_q <= FLOOR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DET_FLOOR) begin
      det_floor_q <= pwdata[FLOOR_W-1:0];
    end
  end

  amx_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (in_data_i),
    .busy_o  (busy),
    .take_i  (q_take),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  amx_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .take_o      (q_take),
    .det_floor_i (det_floor_q),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

@@ hdl/amx_front.sv @@
// Front end: takes transactions and holds them in a two-entry queue for the engine.
module amx_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  amx_pkg::in_t item_i,
  output logic         busy_o,
  input  logic         take_i,
  output logic         valid_o,
  output amx_pkg::in_t item_o
);
  import amx_pkg::*;

  in_t        mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  // Accept while a slot is free; the engine pops when it goes idle.
  assign busy_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign push    = start_i && !busy_o;
  assign pop     = take_i && valid_o;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hdl/amx_back.sv @@
// Engine: cofactors, determinant, long division and inverse translation.
module amx_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  amx_pkg::in_t                  item_i,
  output logic                          take_o,
  input  logic [amx_pkg::FLOOR_W-1:0]   det_floor_i,
  output logic                          res_valid_o,
  output amx_pkg::out_t                 res_o
);
  import amx_pkg::*;

  localparam int unsigned F2 = 2 * FRAC_BITS;
  localparam int unsigned DW = 98;
  localparam int unsigned RW = DW + 34;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COF, ST_DET, ST_FIX, ST_DIV, ST_TRN, ST_TRW, ST_TRR
  } state_e;

  typedef enum logic [1:0] {K_COF, K_DET, K_TRN} kind_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [3:0] idx;
    logic       first;
    logic       shift;
  } pend_t;

  // Operand indexes of the two products of each cofactor.
  function automatic logic [7:0] cof_sel(input logic [3:0] k, input logic term);
    logic [15:0] row;
    case (k)
      4'd0:    row = 16'h4857;
      4'd1:    row = 16'h2718;
      4'd2:    row = 16'h1524;
      4'd3:    row = 16'h5638;
      4'd4:    row = 16'h0826;
      4'd5:    row = 16'h2305;
      4'd6:    row = 16'h3746;
      4'd7:    row = 16'h1607;
      4'd8:    row = 16'h0413;
      default: row = 16'h0000;
    endcase
    return term ? row[7:0] : row[15:8];
  endfunction

  function automatic logic signed [31:0] sat32(input logic neg, input logic [66:0] mag);
    logic signed [31:0] r;
    if (!neg) begin
      r = (mag > 67'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    end else begin
      r = (mag > 67'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - mag[31:0]);
    end
    return r;
  endfunction

  state_e               state_q;
  logic [5:0]           cnt_q;
  logic [3:0]           k_q;
  logic [1:0]           j_q, col_q;
  pend_t                pend_q, pend_d;
  logic                 res_valid_q;

  logic signed [31:0]   vin [12];
  logic signed [31:0]   v_q [12];
  logic signed [31:0]   o_q [12];
  logic signed [64:0]   c_q [9];
  logic signed [65:0]   t_q [3];
  logic signed [65:0]   prod_q;
  logic signed [DW-1:0] det_q;
  logic [DW-1:0]        d_q;
  logic                 det_neg_q;
  logic [RW-1:0]        rem_q, dsh_q;
  logic [33:0]          q_q;
  logic                 sat_q;
  out_t                 res_q;

  logic signed [32:0]   mul_a, mul_b;
  logic [7:0]           sel;
  logic [3:0]           ci;
  logic signed [DW-1:0] det_term;
  logic [DW-1:0]        dabs, thr;
  logic [FLOOR_W-1:0]   fl;
  logic signed [64:0]   ck;
  logic [64:0]          cabs;
  logic                 ge, rnd, dneg;
  logic [34:0]          qr;
  logic signed [31:0]   tr [3];

  assign take_o      = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Unpack the incoming transaction into operand slots.
  always_comb begin
    vin[0]  = item_i.lin_00;
    vin[1]  = item_i.lin_01;
    vin[2]  = item_i.lin_02;
    vin[3]  = item_i.lin_10;
    vin[4]  = item_i.lin_11;
    vin[5]  = item_i.lin_12;
    vin[6]  = item_i.lin_20;
    vin[7]  = item_i.lin_21;
    vin[8]  = item_i.lin_22;
    vin[9]  = item_i.shift_x;
    vin[10] = item_i.shift_y;
    vin[11] = item_i.shift_z;
  end

  // Operand selection for the shared multiplier and its accumulate tag.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    pend_d = '0;
    sel    = cof_sel(cnt_q[4:1], cnt_q[0]);
    ci     = 4'(3 * cnt_q[2:1]);
    case (state_q)
      ST_COF: begin
        mul_a  = 33'(v_q[sel[7:4]]);
        mul_b  = 33'(v_q[sel[3:0]]);
        pend_d = '{valid: 1'b1, kind: K_COF, idx: cnt_q[4:1], first: !cnt_q[0],
                   shift: 1'b0};
      end
      ST_DET: begin
        mul_a  = 33'(v_q[{2'b00, cnt_q[2:1]}]);
        mul_b  = cnt_q[0] ? $signed(c_q[ci][64:32]) : $signed({1'b0, c_q[ci][31:0]});
        pend_d = '{valid: 1'b1, kind: K_DET, idx: 4'd0, first: (cnt_q == 6'd0),
                   shift: cnt_q[0]};
      end
      ST_TRN: begin
        mul_a  = 33'(v_q[4'(9 + j_q)]);
        mul_b  = 33'(o_q[4'(3 * j_q + col_q)]);
        pend_d = '{valid: 1'b1, kind: K_TRN, idx: {2'b00, col_q}, first: (j_q == 2'd0),
                   shift: 1'b0};
      end
      default: ;
    endcase
  end

  // Determinant clamp, division step and translation rounding.
  always_comb begin
    det_term = pend_q.shift ? $signed({prod_q, 32'b0}) : DW'(prod_q);
    fl       = (det_floor_i == '0) ? FLOOR_W'(1) : det_floor_i;
    thr      = DW'(fl) << F2;
    dabs     = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    ck       = c_q[k_q];
    cabs     = ck[64] ? 65'(-ck) : 65'(ck);
    ge       = (rem_q >= dsh_q);
    rnd      = ((rem_q << 1) >= RW'(d_q));
    qr       = {1'b0, q_q} + 35'(rnd);
    dneg     = ck[64] ^ det_neg_q;
    for (int i = 0; i < 3; i++) begin
      logic signed [65:0] s;
      logic [65:0]        mag;
      s     = -t_q[i];
      mag   = s[65] ? 66'(-s) : 66'(s);
      tr[i] = sat32(s[65], 67'(mag >> FRAC_BITS) + 67'(mag[FRAC_BITS-1]));
    end
  end

  // Sequencer state and registered result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      j_q         <= '0;
      col_q       <= '0;
      pend_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      res_valid_q <= (state_q == ST_TRR);
      case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            state_q <= ST_COF;
            cnt_q   <= '0;
          end
        end
        ST_COF: begin
          if (cnt_q == 6'd17) begin
            state_q <= ST_DET;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_DET: begin
          if (cnt_q == 6'd5) begin
            state_q <= ST_FIX;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        // Wait until the last determinant term has landed.
        ST_FIX: begin
          if (!pend_q.valid) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
            k_q     <= '0;
          end
        end
        ST_DIV: begin
          if (cnt_q == 6'd35) begin
            cnt_q <= '0;
            if (k_q == 4'd8) begin
              state_q <= ST_TRN;
              j_q     <= '0;
              col_q   <= '0;
            end else begin
              k_q <= k_q + 4'd1;
            end
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_TRN: begin
          if (j_q == 2'd2) begin
            j_q <= '0;
            if (col_q == 2'd2) begin
              state_q <= ST_TRW;
            end else begin
              col_q <= col_q + 2'd1;
            end
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
        ST_TRW: state_q <= ST_TRR;
        ST_TRR: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == ST_IDLE && valid_i) begin
      v_q <= vin;
    end
    // Accumulate the product issued in the previous cycle.
    if (pend_q.valid) begin
      case (pend_q.kind)
        K_COF: c_q[pend_q.idx] <= pend_q.first ? $signed(prod_q[64:0])
                                               : c_q[pend_q.idx] - $signed(prod_q[64:0]);
        K_DET: det_q <= pend_q.first ? det_term : det_q + det_term;
        K_TRN: t_q[pend_q.idx[1:0]] <= pend_q.first ? prod_q
                                                    : t_q[pend_q.idx[1:0]] + prod_q;
        default: ;
      endcase
    end
    // Clamp small determinants to the positive floor once the sum is complete.
    if (state_q == ST_FIX && !pend_q.valid) begin
      if (dabs < thr) begin
        d_q       <= thr;
        det_neg_q <= 1'b0;
      end else begin
        d_q       <= dabs;
        det_neg_q <= det_q[DW-1];
      end
    end
    // Restoring division, one quotient bit per cycle.
    if (state_q == ST_DIV) begin
      if (cnt_q == 6'd0) begin
        rem_q <= RW'(cabs) << F2;
        dsh_q <= RW'(d_q) << 33;
        q_q   <= '0;
      end else if (cnt_q == 6'd1) begin
        sat_q <= ge;
        dsh_q <= dsh_q >> 1;
      end else if (cnt_q == 6'd35) begin
        o_q[k_q] <= sat_q ? (dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                          : sat32(dneg, 67'(qr));
      end else begin
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
        q_q   <= {q_q[32:0], ge};
        dsh_q <= dsh_q >> 1;
      end
    end
    // Result register.
    if (state_q == ST_TRR) begin
      res_q <= '{inv_00: o_q[0], inv_01: o_q[1], inv_02: o_q[2],
                 inv_10: o_q[3], inv_11: o_q[4], inv_12: o_q[5],
                 inv_20: o_q[6], inv_21: o_q[7], inv_22: o_q[8],
                 inv_shift_x: tr[0], inv_shift_y: tr[1], inv_shift_z: tr[2]};
    end
  end

endmodule

@@ bench/affine_matrix_inverse_tb.sv @@
// Self-checking testbench for the affine matrix inverse block.
module affine_matrix_inverse_tb;
  import amx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = 16;
  localparam logic [2:0] ADDR_DET_FLOOR = 3'(REG_DET_FLOOR) << 2;
  localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned ONE_Q = 32'h0001_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data_i = '0;
  logic        result_valid_o;
  out_t        result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the determinant floor register.
  logic [FLOOR_W-1:0] floor_shadow = FLOOR_RESET;
  out_t        inverse_expected[$];
  int unsigned mismatches = 0;
  int unsigned sender_idle_pct = 0;

  affine_matrix_inverse uut (.*);

  always #1 clk_i = ~clk_i;

  // Saturate a sign and magnitude to a signed 32-bit word.
  function automatic logic [31:0] clamp32(bit neg, logic [127:0] mag);
    if (!neg) return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    return (mag > 128'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
  endfunction

  // Exact 2x2 cofactor p*q - r*s at full width.
  function automatic logic signed [127:0] minor2(longint p, longint q, longint r, longint s);
    logic signed [127:0] a, b;
    a = p * q;
    b = r * s;
    return a - b;
  endfunction

  function automatic logic [127:0] mag128(logic signed [127:0] x);
    return (x < 0) ? -x : x;
  endfunction

  // Inverse of one affine transform under the given floor.
  function automatic out_t predict_inverse(in_t x, logic [FLOOR_W-1:0] fl);
    longint v[12];
    longint o[12];
    logic signed [127:0] cf[9];
    logic signed [127:0] det, s;
    logic [127:0] thr, dmag, num, q, r, m;
    logic [383:0] flat;
    out_t res;
    flat = x;
    for (int k = 0; k < 12; k++) v[k] = $signed(flat[(11-k)*32 +: 32]);
    cf[0] = minor2(v[4], v[8], v[5], v[7]);
    cf[1] = minor2(v[2], v[7], v[1], v[8]);
    cf[2] = minor2(v[1], v[5], v[2], v[4]);
    cf[3] = minor2(v[5], v[6], v[3], v[8]);
    cf[4] = minor2(v[0], v[8], v[2], v[6]);
    cf[5] = minor2(v[2], v[3], v[0], v[5]);
    cf[6] = minor2(v[3], v[7], v[4], v[6]);
    cf[7] = minor2(v[1], v[6], v[0], v[7]);
    cf[8] = minor2(v[0], v[4], v[1], v[3]);
    det = v[0] * cf[0] + v[1] * cf[3] + v[2] * cf[6];
    // A floor of zero behaves as one; small determinants become +floor.
    thr = 128'((fl == 0) ? 1 : fl) << (2 * FRAC);
    if (mag128(det) < thr) det = thr;
    dmag = mag128(det);
    for (int k = 0; k < 9; k++) begin
      num = mag128(cf[k]) << (2 * FRAC);
      q = num / dmag;
      r = num % dmag;
      if ((r << 1) >= dmag) q = q + 1;
      o[k] = $signed(clamp32((cf[k] < 0) != (det < 0), q));
    end
    for (int c = 0; c < 3; c++) begin
      s = v[9] * o[c];
      s = s + v[10] * o[3+c];
      s = s + v[11] * o[6+c];
      s = -s;
      m = mag128(s);
      q = m >> FRAC;
      if (m[FRAC-1]) q = q + 1;
      o[9+c] = $signed(clamp32(s < 0, q));
    end
    for (int k = 0; k < 12; k++) flat[(11-k)*32 +: 32] = o[k][31:0];
    res = flat;
    return res;
  endfunction

  // Compare one result against the oldest expectation, field by field.
  function automatic void check_result(out_t got, out_t want);
    logic [383:0] g, w;
    bit bad;
    g = got;
    w = want;
    bad = 0;
    for (int k = 0; k < 12; k++) begin
      if (g[(11-k)*32 +: 32] !== w[(11-k)*32 +: 32]) begin
        bad = 1;
        if (mismatches < MAX_REPORTS)
          $display("Mismatch field %0d: expected %h, got %h", k,
                   w[(11-k)*32 +: 32], g[(11-k)*32 +: 32]);
      end
    end
    if (bad) mismatches++;
  endfunction

  // Result monitor: every strobe consumes one expectation, or is flagged if none is left.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (inverse_expected.size() == 0) begin
        if (mismatches < MAX_REPORTS) $display("Unexpected result %h", result_o);
        mismatches++;
      end else begin
        check_result(result_o, inverse_expected.pop_front());
      end
    end
  end

  // One APB write; only issued while the block is idle.
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_DET_FLOOR) floor_shadow = data[FLOOR_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Issue one transaction; start stays high across back-to-back items.
  task automatic send_transform(in_t d, bit typed, out_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (busy);
    inverse_expected.push_back(typed ? want : predict_inverse(d, floor_shadow));
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (inverse_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Random Q16.16 value: mostly near unit scale, sometimes raw, tiny or extreme.
  function automatic logic [31:0] rand_entry(int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 * ONE_Q)) - $signed(4 * ONE_Q));
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic in_t rand_transform();
    logic [383:0] flat;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) begin
      case (mode)
        0, 1: flat[k*32 +: 32] = rand_entry($urandom_range(0, 3));
        2: flat[k*32 +: 32] = rand_entry(0);
        3: flat[k*32 +: 32] = rand_entry(3);
        default: flat[k*32 +: 32] = rand_entry(1);
      endcase
    end
    // Singular case: row 2 copies row 0.
    if (mode == 4) flat[383-192 -: 96] = flat[383 -: 96];
    return in_t'(flat);
  endfunction

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t want;
  } vector_t;

  function automatic in_t diag(logic [31:0] a, logic [31:0] sx, logic [31:0] sy,
                               logic [31:0] sz);
    in_t t;
    t = '0;
    t.lin_00 = a;
    t.lin_11 = a;
    t.lin_22 = a;
    t.shift_x = sx;
    t.shift_y = sy;
    t.shift_z = sz;
    return t;
  endfunction

  // Stimulus.
  initial begin
    vector_t table_v[$];
    vector_t row;
    logic [31:0] floors[5];
    out_t none;
    none = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Identity with a translation: the inverse translation is negated.
    row.stim = diag(ONE_Q, ONE_Q, 2 * ONE_Q, -3 * ONE_Q);
    row.typed = 1;
    row.want = '0;
    row.want.inv_00 = ONE_Q;
    row.want.inv_11 = ONE_Q;
    row.want.inv_22 = ONE_Q;
    row.want.inv_shift_x = -ONE_Q;
    row.want.inv_shift_y = -2 * ONE_Q;
    row.want.inv_shift_z = 3 * ONE_Q;
    table_v.push_back(row);
    // Zero matrix: determinant floored, all cofactors zero.
    row.stim = '0;
    row.stim.shift_x = 32'h7FFF_FFFF;
    row.want = '0;
    table_v.push_back(row);
    // Rows checked against the predictor.
    row.typed = 0;
    row.want = none;
    row.stim = {12{32'h7FFF_FFFF}};
    table_v.push_back(row);
    row.stim = {12{32'h8000_0000}};
    table_v.push_back(row);
    row.stim = diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    table_v.push_back(row);
    row.stim = diag(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
    table_v.push_back(row);
    row.stim = diag(2 * ONE_Q, ONE_Q, 32'h1, 32'hFFFF_FFFF);
    table_v.push_back(row);
    row.stim = diag(3, 5, 7, 9);          // tiny determinant, clamped to the floor
    table_v.push_back(row);
    row.stim = diag(-3 * ONE_Q, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_8000);
    table_v.push_back(row);
    row.stim = diag(4 * ONE_Q, 32'h0000_0002, 32'hFFFF_FFFE, 32'h0000_0006);
    table_v.push_back(row);
    row.stim = diag(32'h0000_0100, 32'h7FFF_FFFF, 0, 0); // full-scale translation, determinant floored
    table_v.push_back(row);
    for (int i = 0; i < 6; i++) begin
      row.stim = rand_transform();
      table_v.push_back(row);
    end

    foreach (table_v[i]) send_transform(table_v[i].stim, table_v[i].typed, table_v[i].want);
    drain();

    // Random phases under several floors and idle patterns.
    floors[0] = 32'd65536;
    floors[1] = 32'd0;
    floors[2] = 32'h0001_FFFF;
    floors[3] = $urandom();
    floors[4] = 32'd1;
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(ADDR_DET_FLOOR, floors[ph]);
      reg_write(ADDR_UNMAPPED, $urandom());
      case (ph)
        1: sender_idle_pct = 86;
        3: sender_idle_pct = 18;
        default: sender_idle_pct = 0;
      endcase
      for (int i = 0; i < 270; i++) send_transform(rand_transform(), 0, none);
      drain();
    end
    reg_write(ADDR_DET_FLOOR, floors[4]);
    sender_idle_pct = 0;
    for (int i = 0; i < 20; i++) send_transform(rand_transform(), 0, none);
    drain();

    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && inverse_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
